// ===== hw/rtl/vts_pkg.sv =====
package vts_pkg;

   // grid geometry: RESOLUTION^3 voxels, split into eight banks by coordinate parity
   localparam int RESOLUTION = 128;
   localparam int RES_BITS   = $clog2(RESOLUTION);
   localparam int STORE_BITS = 3 * RES_BITS;
   localparam int BANK_BITS  = 3 * (RES_BITS - 1);
   localparam int BANK_DEPTH = 1 << BANK_BITS;
   localparam int BANKS      = 8;

   // lattice index width after the scale product and the half voxel offset
   localparam int IDX_W = 26;

   // decoupling queue between front and back
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      CSR_BOX_MIN_X = 2'd0,
      CSR_BOX_MIN_Y = 2'd1,
      CSR_BOX_MIN_Z = 2'd2,
      CSR_VOX_SCALE = 2'd3
   } csr_index_type;

   localparam logic signed [31:0] BOX_MIN_RESET = -32'sd1966080;
   localparam logic [23:0]        VOX_SCALE_RESET = 24'd139810;

   // one axis after classification
   typedef struct packed {
      logic [RES_BITS-1:0] c0;    // low bits of lower lattice index
      logic                v0;    // lower neighbor inside grid
      logic                v1;    // upper neighbor inside grid
      logic [15:0]         frac;  // Q0.16 fraction
   } axis_type;

   typedef struct packed {
      logic                  cmd;
      logic [STORE_BITS-1:0] waddr;
      logic [15:0]           wdata;
      axis_type              ax;
      axis_type              ay;
      axis_type              az;
   } lat_item_type;

endpackage

// ===== hw/rtl/vts_front.sv =====
module vts_front import vts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_cmd,
   input  logic [20:0]           req_voxel_index,
   input  logic [15:0]           req_voxel_value,
   input  logic signed [31:0]    req_point_x,
   input  logic signed [31:0]    req_point_y,
   input  logic signed [31:0]    req_point_z,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  q_full,
   output logic                  q_push,
   output lat_item_type          q_item
);

   logic signed [31:0] bmin_x_ff, bmin_y_ff, bmin_z_ff;
   logic [23:0]        scale_ff;

   logic                  f1_valid_ff, f1_valid_in;
   logic                  f1_cmd_ff;
   logic [STORE_BITS-1:0] f1_waddr_ff;
   logic [15:0]           f1_wdata_ff;
   logic signed [32:0]    f1_d_ff [3];
   logic signed [32:0]    f1_d_in [3];

   logic                  f2_valid_ff;
   logic                  f2_cmd_ff;
   logic [STORE_BITS-1:0] f2_waddr_ff;
   logic [15:0]           f2_wdata_ff;
   logic signed [56:0]    f2_prod_ff [3];
   logic signed [57:0]    f2_prod_in [3];

   logic adv;

   function automatic axis_type classify(input logic signed [56:0] prod);
      logic signed [57:0]      t;
      logic signed [IDX_W-1:0] idx;
      axis_type                a;
      // floor(prod/2^16) - 2^15, then floor by 2^16: one offset on the full product
      t      = {prod[56], prod} - 58'sd2147483648;
      idx    = t[57:32];
      a.c0   = idx[RES_BITS-1:0];
      a.frac = t[31:16];
      a.v0   = (idx >= 0) && (idx <= IDX_W'(RESOLUTION - 1));
      a.v1   = (idx >= -26'sd1) && (idx <= IDX_W'(RESOLUTION - 2));
      return a;
   endfunction

   assign adv      = !q_full;
   assign req_full = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         bmin_x_ff <= BOX_MIN_RESET;
         bmin_y_ff <= BOX_MIN_RESET;
         bmin_z_ff <= BOX_MIN_RESET;
         scale_ff  <= VOX_SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOX_MIN_X: bmin_x_ff <= csr_data;
            CSR_BOX_MIN_Y: bmin_y_ff <= csr_data;
            CSR_BOX_MIN_Z: bmin_z_ff <= csr_data;
            CSR_VOX_SCALE: scale_ff  <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      f1_valid_in = req_push && !q_full;
      f1_d_in[0]  = {req_point_x[31], req_point_x} - {bmin_x_ff[31], bmin_x_ff};
      f1_d_in[1]  = {req_point_y[31], req_point_y} - {bmin_y_ff[31], bmin_y_ff};
      f1_d_in[2]  = {req_point_z[31], req_point_z} - {bmin_z_ff[31], bmin_z_ff};
      for (int a = 0; a < 3; a++) begin
         f2_prod_in[a] = f1_d_ff[a] * $signed({1'b0, scale_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_cmd_ff   <= req_cmd;
         f1_waddr_ff <= req_voxel_index[STORE_BITS-1:0];
         f1_wdata_ff <= req_voxel_value;
         f2_cmd_ff   <= f1_cmd_ff;
         f2_waddr_ff <= f1_waddr_ff;
         f2_wdata_ff <= f1_wdata_ff;
         for (int a = 0; a < 3; a++) begin
            f1_d_ff[a]    <= f1_d_in[a];
            f2_prod_ff[a] <= f2_prod_in[a][56:0];
         end
      end
   end

   always_comb begin
      q_push       = f2_valid_ff && adv;
      q_item.cmd   = f2_cmd_ff;
      q_item.waddr = f2_waddr_ff;
      q_item.wdata = f2_wdata_ff;
      q_item.ax    = classify(f2_prod_ff[0]);
      q_item.ay    = classify(f2_prod_ff[1]);
      q_item.az    = classify(f2_prod_ff[2]);
   end

endmodule

// ===== hw/rtl/vts_queue.sv =====
module vts_queue import vts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lat_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output lat_item_type head_item
);

   lat_item_type        slot_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wptr_ff, rptr_ff;
   logic [Q_PTR_BITS:0]   count_ff, count_in;

   assign full      = (count_ff == (Q_PTR_BITS+1)'(Q_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = slot_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_item;
   end

endmodule

// ===== hw/rtl/vts_back.sv =====
module vts_back import vts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  lat_item_type q_item,
   output logic         q_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output logic [15:0]  rsp_density
);

   logic adv, take;

   logic [BANK_BITS-1:0] addr_in [BANKS];
   logic                 we_in   [BANKS];
   logic [16:0]          wx_in [BANKS], wy_in [BANKS], wz_in [BANKS];
   logic                 vin_in [BANKS];

   logic [15:0] rd_ff [BANKS];
   logic [16:0] b1_wx_ff [BANKS], b1_wy_ff [BANKS], b1_wz_ff [BANKS];
   logic        b1_in_ff [BANKS];

   logic [33:0] b2_wxy_ff [BANKS];
   logic [16:0] b2_wz_ff  [BANKS];
   logic [15:0] b2_dens_ff [BANKS];

   logic [50:0] wxyz_full [BANKS];
   logic [48:0] b3_wxyz_ff [BANKS];
   logic [15:0] b3_dens_ff [BANKS];

   logic [64:0] term_full [BANKS];
   logic [63:0] b4_term_ff [BANKS];
   logic [63:0] b5_sum_ff [4];
   logic [63:0] b6_sum_ff [2];
   logic [63:0] total;

   logic b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff, b5_valid_ff, b6_valid_ff;
   logic out_valid_ff;
   logic [15:0] out_density_ff;

   assign adv   = !out_valid_ff || rsp_pop;
   assign take  = adv && !q_empty;
   assign q_pop = take;

   function automatic logic [RES_BITS-1:0] pick(input logic [RES_BITS-1:0] c0,
                                                input logic parity);
      return (c0[0] == parity) ? c0 : c0 + 1'b1;
   endfunction

   function automatic logic [16:0] weight(input axis_type a, input logic parity);
      return (a.c0[0] == parity) ? (17'h10000 - {1'b0, a.frac}) : {1'b0, a.frac};
   endfunction

   function automatic logic inside_grid(input axis_type a, input logic parity);
      return (a.c0[0] == parity) ? a.v0 : a.v1;
   endfunction

   // bank = parity of (z,y,x); row inside bank = coordinates with parity dropped
   always_comb begin
      logic [RES_BITS-1:0] wxc, wyc, wzc, sx, sy, sz;
      logic [2:0]          wbank;
      wxc   = q_item.waddr[RES_BITS-1:0];
      wyc   = q_item.waddr[2*RES_BITS-1:RES_BITS];
      wzc   = q_item.waddr[3*RES_BITS-1:2*RES_BITS];
      wbank = {wzc[0], wyc[0], wxc[0]};
      for (int b = 0; b < BANKS; b++) begin
         sx = pick(q_item.ax.c0, b[0]);
         sy = pick(q_item.ay.c0, b[1]);
         sz = pick(q_item.az.c0, b[2]);
         if (q_item.cmd == CMD_WRITE) begin
            addr_in[b] = {wzc[RES_BITS-1:1], wyc[RES_BITS-1:1], wxc[RES_BITS-1:1]};
         end else begin
            addr_in[b] = {sz[RES_BITS-1:1], sy[RES_BITS-1:1], sx[RES_BITS-1:1]};
         end
         we_in[b]  = take && (q_item.cmd == CMD_WRITE) && (wbank == 3'(b));
         wx_in[b]  = weight(q_item.ax, b[0]);
         wy_in[b]  = weight(q_item.ay, b[1]);
         wz_in[b]  = weight(q_item.az, b[2]);
         vin_in[b] = inside_grid(q_item.ax, b[0]) && inside_grid(q_item.ay, b[1]) &&
                     inside_grid(q_item.az, b[2]);
      end
   end

   for (genvar g = 0; g < BANKS; g++) begin : g_bank
      logic [15:0] bank_mem [BANK_DEPTH];
      always_ff @(posedge clock) begin
         if (we_in[g]) bank_mem[addr_in[g]] <= q_item.wdata;
      end
      always_ff @(posedge clock) begin
         if (adv) rd_ff[g] <= bank_mem[addr_in[g]];
      end
   end

   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         wxyz_full[b] = b2_wxy_ff[b] * b2_wz_ff[b];
         term_full[b] = b3_wxyz_ff[b] * b3_dens_ff[b];
      end
      // weights sum to 2^48, so the blend never exceeds 2^64 and the top word fits 16 bits
      total = b6_sum_ff[0] + b6_sum_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         b5_valid_ff  <= 1'b0;
         b6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= take && (q_item.cmd == CMD_SAMPLE);
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         b5_valid_ff  <= b4_valid_ff;
         b6_valid_ff  <= b5_valid_ff;
         out_valid_ff <= b6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int b = 0; b < BANKS; b++) begin
            b1_wx_ff[b]   <= wx_in[b];
            b1_wy_ff[b]   <= wy_in[b];
            b1_wz_ff[b]   <= wz_in[b];
            b1_in_ff[b]   <= vin_in[b];
            b2_wxy_ff[b]  <= b1_wx_ff[b] * b1_wy_ff[b];
            b2_wz_ff[b]   <= b1_wz_ff[b];
            b2_dens_ff[b] <= b1_in_ff[b] ? rd_ff[b] : 16'd0;
            b3_wxyz_ff[b] <= wxyz_full[b][48:0];
            b3_dens_ff[b] <= b2_dens_ff[b];
            b4_term_ff[b] <= term_full[b][63:0];
         end
         for (int k = 0; k < 4; k++) begin
            b5_sum_ff[k] <= b4_term_ff[2*k] + b4_term_ff[2*k+1];
         end
         for (int k = 0; k < 2; k++) begin
            b6_sum_ff[k] <= b5_sum_ff[2*k] + b5_sum_ff[2*k+1];
         end
         out_density_ff <= total[63:48];
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_density = out_density_ff;

endmodule

// ===== hw/rtl/volume_trilinear_sample_unit.sv =====
// channel | ports                                                  | beat moves
// req     | req_push / req_full, req_cmd, req_voxel_*, req_point_* | one write or sample
// rsp     | rsp_pop / rsp_empty, rsp_density                       | one blended density
// csr     | csr_valid / csr_ready, csr_index, csr_data             | one register write
//
// One beat per cycle in and one per cycle out while neither side stalls; after acceptance a
// sample passes two front stages, the queue, bank read, three multiply stages and the add tree.
// Reset clears pipeline valids and queue pointers and loads register defaults;
// the voxel banks are not cleared. An output stall freezes the back pipeline,
// then the four-deep queue fills and req_full rises.
module volume_trilinear_sample_unit import vts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_cmd,
   input  logic [20:0]        req_voxel_index,
   input  logic [15:0]        req_voxel_value,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [15:0]        rsp_density,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic         q_push, q_full, q_pop, q_empty;
   lat_item_type q_in_item, q_head_item;

   // registers are plain flops, always writable
   assign csr_ready = 1'b1;

   // front: register file, box offset, scale multiply, lattice classify
   vts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_voxel_index (req_voxel_index),
      .req_voxel_value (req_voxel_value),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_in_item)
   );

   vts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head_item)
   );

   // back: eight parity banks, weight products, add tree, output register
   vts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_item      (q_head_item),
      .q_pop       (q_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_density (rsp_density)
   );

endmodule

// ===== verif/volume_trilinear_sample_unit_tb.sv =====
module volume_trilinear_sample_unit_tb;
   import vts_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_cmd = CMD_WRITE;
   logic [20:0]        req_voxel_index = '0;
   logic [15:0]        req_voxel_value = '0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [15:0]        rsp_density;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   volume_trilinear_sample_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_voxel_index (req_voxel_index),
      .req_voxel_value (req_voxel_value),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_density     (rsp_density),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the block's registers and of every voxel written so far.
   longint            shadow_box_min [3];
   longint            shadow_scale;
   logic [15:0]       voxel_shadow [int];

   logic [15:0]       density_expected [$];
   int                error_count = 0;

   // idle controls, in percent per cycle, plus a receiver hold length
   int                send_idle_pct = 0;
   int                pop_stall_pct = 0;
   int                pop_hold_cycles = 0;

   // Map one axis to lattice index and Q0.16 fraction: offset, scale, minus half voxel, floor.
   function automatic void axis_map(input longint pt, input longint bmin,
                                    output longint idx, output longint frac);
      longint d, prod, v, l;
      d    = pt - bmin;
      prod = d * shadow_scale;
      v    = prod >>> 16;
      l    = v - 32768;
      idx  = l >>> 16;
      frac = l & 64'hFFFF;
   endfunction

   function automatic bit in_grid(input longint x, input longint y, input longint z);
      return x >= 0 && x < RESOLUTION && y >= 0 && y < RESOLUTION &&
             z >= 0 && z < RESOLUTION;
   endfunction

   function automatic int grid_addr(input longint x, input longint y, input longint z);
      return int'(((z * RESOLUTION + y) * RESOLUTION + x) & 64'h1FFFFF);
   endfunction

   function automatic logic [15:0] blend_density(input longint px, input longint py,
                                                 input longint pz);
      longint xi, yi, zi, fx, fy, fz;
      longint unsigned wx [2], wy [2], wz [2];
      longint unsigned acc, w, res;
      longint unsigned vox;
      axis_map(px, shadow_box_min[0], xi, fx);
      axis_map(py, shadow_box_min[1], yi, fy);
      axis_map(pz, shadow_box_min[2], zi, fz);
      wx[0] = 65536 - fx; wx[1] = fx;
      wy[0] = 65536 - fy; wy[1] = fy;
      wz[0] = 65536 - fz; wz[1] = fz;
      acc = 0;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++) begin
               w = wx[i] * wy[j] * wz[k];
               vox = 0;
               if (in_grid(xi + i, yi + j, zi + k))
                  vox = 64'(voxel_shadow[grid_addr(xi + i, yi + j, zi + k)]);
               acc += w * vox;
            end
      res = acc >> 48;
      if (res > 65535) res = 65535;
      return res[15:0];
   endfunction

   // One beat on the request side; prediction happens at the accepting edge.
   task automatic push_beat(input logic cmd, input logic [20:0] vidx, input logic [15:0] vval,
                            input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] pz);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push = 1'b0;
      end
      @(negedge clock);
      req_push        = 1'b1;
      req_cmd         = cmd;
      req_voxel_index = vidx;
      req_voxel_value = vval;
      req_point_x     = px;
      req_point_y     = py;
      req_point_z     = pz;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (cmd == CMD_WRITE)
         voxel_shadow[int'(vidx)] = vval;
      else
         density_expected.push_back(blend_density(px, py, pz));
   endtask

   task automatic write_voxel(input logic [20:0] vidx, input logic [15:0] vval);
      push_beat(CMD_WRITE, vidx, vval, $urandom, $urandom, $urandom);
   endtask

   // Loads any in-grid neighbor not yet written, then samples, so no read hits
   // an unwritten voxel.
   task automatic sample_point(input logic signed [31:0] px, input logic signed [31:0] py,
                               input logic signed [31:0] pz);
      longint xi, yi, zi, f;
      int a;
      axis_map(px, shadow_box_min[0], xi, f);
      axis_map(py, shadow_box_min[1], yi, f);
      axis_map(pz, shadow_box_min[2], zi, f);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++)
               if (in_grid(xi + i, yi + j, zi + k)) begin
                  a = grid_addr(xi + i, yi + j, zi + k);
                  if (!voxel_shadow.exists(a))
                     write_voxel(a[20:0], 16'($urandom));
               end
      push_beat(CMD_SAMPLE, 21'($urandom), 16'($urandom), px, py, pz);
   endtask

   // coordinate around the box on one axis, with a margin past both faces
   function automatic logic signed [31:0] near_coord(input longint bmin);
      longint span, off, p;
      span = (shadow_scale != 0) ? ((64'd130 <<< 32) / shadow_scale) : 64'd65536;
      off  = longint'({$urandom, $urandom} % (span + 64'd262144)) - 64'd131072;
      p    = bmin + off;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   task automatic random_items(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 15)
            write_voxel(21'($urandom), 16'($urandom));
         else if (pick < 30)
            sample_point($urandom, $urandom, $urandom);
         else
            sample_point(near_coord(shadow_box_min[0]), near_coord(shadow_box_min[1]),
                         near_coord(shadow_box_min[2]));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (density_expected.size() != 0) @(posedge clock);
      // writes leave no result; let the pipe settle before touching registers
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BOX_MIN_X: shadow_box_min[0] = longint'($signed(value));
         CSR_BOX_MIN_Y: shadow_box_min[1] = longint'($signed(value));
         CSR_BOX_MIN_Z: shadow_box_min[2] = longint'($signed(value));
         CSR_VOX_SCALE: shadow_scale = longint'(value[23:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_geometry(input logic [31:0] bx, input logic [31:0] by,
                               input logic [31:0] bz, input logic [23:0] scale);
      csr_write(CSR_BOX_MIN_X, bx);
      csr_write(CSR_BOX_MIN_Y, by);
      csr_write(CSR_BOX_MIN_Z, bz);
      csr_write(CSR_VOX_SCALE, {8'd0, scale});
   endtask

   // Result side: pop at random, check each beat against the oldest prediction.
   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (pop_hold_cycles > 0) begin
            pop_hold_cycles--;
            rsp_pop = 1'b0;
         end else begin
            rsp_pop = ($urandom_range(99) >= pop_stall_pct);
         end
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (density_expected.size() == 0) begin
               $display("%0t: unexpected density beat, actual %h", $time, rsp_density);
               error_count++;
            end else if (rsp_density !== density_expected[0]) begin
               $display("%0t: density mismatch, expected %h actual %h", $time,
                        density_expected[0], rsp_density);
               error_count++;
               void'(density_expected.pop_front());
            end else begin
               void'(density_expected.pop_front());
            end
         end
      end
   end

   // Extremes of fields, grid corners, zero scale, outside points.
   task automatic test_directed();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      write_voxel(21'd0, 16'hFFFF);
      write_voxel(21'h1FFFFF, 16'h0000);
      write_voxel(21'h0AAAAA, 16'h8001);
      sample_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      sample_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      sample_point(BOX_MIN_RESET, BOX_MIN_RESET, BOX_MIN_RESET);   // lower face, half voxel
      sample_point(32'sd0, 32'sd0, 32'sd0);
      sample_point(-BOX_MIN_RESET, -BOX_MIN_RESET, -BOX_MIN_RESET);  // upper face
      sample_point(-BOX_MIN_RESET - 32'sd1, 32'sd0, BOX_MIN_RESET + 32'sd1);
      sample_point(32'sh8000_0000, 32'sd0, 32'sh7FFF_FFFF);
      // zero scale pins every point at lattice minus one half
      csr_write(CSR_VOX_SCALE, 32'd0);
      sample_point(32'sd12345, -32'sd999, 32'sh7FFF_FFFF);
      sample_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      csr_write(CSR_VOX_SCALE, 32'h00FF_FFFF);
      sample_point(BOX_MIN_RESET, BOX_MIN_RESET + 32'sd256, BOX_MIN_RESET + 32'sd100);
      csr_write(CSR_VOX_SCALE, {8'd0, VOX_SCALE_RESET});
   endtask

   task automatic test_no_idle();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      random_items(60);
   endtask

   task automatic test_sender_idle();
      set_geometry(-32'sd100000, 32'sd5000, -32'sd65536, 24'd65536);
      send_idle_pct = 87;
      pop_stall_pct = 0;
      random_items(60);
   endtask

   task automatic test_receiver_stall();
      set_geometry($urandom, $urandom, $urandom, 24'($urandom_range(1000, 400000)));
      send_idle_pct = 0;
      pop_stall_pct = 87;
      random_items(50);
   endtask

   task automatic test_both_idle();
      set_geometry(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'hFF_FFFF);
      send_idle_pct = 20;
      pop_stall_pct = 20;
      random_items(60);
      set_geometry(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'd1);
      random_items(40);
      set_geometry(32'sh7FFF_FF00, -32'sd7, 32'sh8000_0100, 24'd0);
      random_items(40);
   endtask

   // Long receiver hold fills the pipe and queue so req_full rises; then a full drain and a shorter hold.
   task automatic test_backpressure();
      set_geometry({BOX_MIN_RESET}, {BOX_MIN_RESET}, {BOX_MIN_RESET}, VOX_SCALE_RESET);
      send_idle_pct = 0;
      pop_stall_pct = 0;
      pop_hold_cycles = 300;
      random_items(20);
      wait_drained();
      pop_hold_cycles = 150;
      random_items(40);
   endtask

   initial begin
      shadow_box_min[0] = BOX_MIN_RESET;
      shadow_box_min[1] = BOX_MIN_RESET;
      shadow_box_min[2] = BOX_MIN_RESET;
      shadow_scale      = VOX_SCALE_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();

      wait_drained();
      if (error_count == 0 && density_expected.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("FAILURE");
      $finish;
   end

endmodule
